/* sv/pcpd_pkg.sv */
// shared types and constants of the patch column post decoder
`default_nettype none

package pcpd_pkg;

  localparam int MaxHeightDef = 256;

  localparam int CfgDataW  = 16;
  localparam int CfgIndexW = 1;

  localparam logic [CfgIndexW-1:0] REG_ORIGIN_ROW     = 1'b0;
  localparam logic [CfgIndexW-1:0] REG_TEXTURE_HEIGHT = 1'b1;

  localparam logic [15:0] OriginRowReset     = 16'sd0;
  localparam logic [8:0]  TextureHeightReset = 9'd128;

  localparam logic [7:0] END_MARK = 8'hFF;

  typedef struct packed {
    logic signed [15:0] origin_row;
    logic [8:0]         texture_height;
  } cfg_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] row;
    logic [7:0] pixel_index;
    logic       column_done;
  } result_t;

endpackage

`default_nettype wire

/* sv/pcpd_cfg_regs.sv */
// configuration registers of the patch column post decoder
`default_nettype none

module pcpd_cfg_regs (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [pcpd_pkg::CfgIndexW-1:0] cfg_index_i,
  input  wire logic [pcpd_pkg::CfgDataW-1:0]  cfg_data_i,
  output pcpd_pkg::cfg_t                      cfg_o
);
  import pcpd_pkg::*;

  logic signed [15:0] origin_row_q;
  logic [8:0]         texture_height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      origin_row_q     <= OriginRowReset;
      texture_height_q <= TextureHeightReset;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_ORIGIN_ROW:     origin_row_q     <= cfg_data_i[15:0];
        REG_TEXTURE_HEIGHT: texture_height_q <= cfg_data_i[8:0];
        default: begin
        end
      endcase
    end
  end

  assign cfg_o.origin_row     = origin_row_q;
  assign cfg_o.texture_height = texture_height_q;

endmodule

`default_nettype wire

/* sv/pcpd_parser.sv */
// post parse state and per-byte row calculation
`default_nettype none

module pcpd_parser #(
  parameter int MAX_HEIGHT = pcpd_pkg::MaxHeightDef
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           step_i,
  input  wire logic [7:0]     data_byte_i,
  input  wire logic           column_start_i,
  input  wire pcpd_pkg::cfg_t cfg_i,
  output pcpd_pkg::result_t   res_o
);
  import pcpd_pkg::*;

  localparam logic [2:0] PH_TOP  = 3'd0;
  localparam logic [2:0] PH_LEN  = 3'd1;
  localparam logic [2:0] PH_PAD1 = 3'd2;
  localparam logic [2:0] PH_PIX  = 3'd3;
  localparam logic [2:0] PH_PAD2 = 3'd4;
  localparam logic [2:0] PH_DONE = 3'd5;

  logic [2:0] phase_q, phase_d;
  logic [7:0] top_q, top_d;
  logic [7:0] len_q, len_d;
  logic [7:0] pos_q, pos_d;
  logic [8:0] col_off_q, col_off_d;
  logic [8:0] written_q, written_d;

  logic [2:0] phase_c;
  logic [7:0] top_c, len_c, pos_c;
  logic [8:0] col_off_c, written_c;

  logic signed [17:0] t_row;
  logic signed [18:0] r_row;
  logic               row_ok;
  logic [7:0]         pos_inc;
  logic [9:0]         off_sum;

  // column start clears everything before the byte is parsed
  always_comb begin
    if (column_start_i) begin
      phase_c   = PH_TOP;
      top_c     = '0;
      len_c     = '0;
      pos_c     = '0;
      col_off_c = '0;
      written_c = '0;
    end else begin
      phase_c   = phase_q;
      top_c     = top_q;
      len_c     = len_q;
      pos_c     = pos_q;
      col_off_c = col_off_q;
      written_c = written_q;
    end
  end

  // origin + top + pixel position; negative means clipped at the top
  assign t_row = 18'(cfg_i.origin_row) + {10'd0, top_c} + {10'd0, pos_c};
  assign r_row = 19'(t_row) + {10'd0, col_off_c};
  assign row_ok = !t_row[17] && (r_row[18:8] == '0)
                  && ({1'b0, r_row[7:0]} < cfg_i.texture_height)
                  && ({24'd0, r_row[7:0]} < 32'(MAX_HEIGHT));
  assign pos_inc = pos_c + 8'd1;
  assign off_sum = {1'b0, col_off_c} + {1'b0, written_c};

  always_comb begin
    phase_d   = phase_c;
    top_d     = top_c;
    len_d     = len_c;
    pos_d     = pos_c;
    col_off_d = col_off_c;
    written_d = written_c;
    res_o     = '0;
    case (phase_c)
      PH_TOP: begin
        if (data_byte_i == END_MARK) begin
          res_o.valid       = 1'b1;
          res_o.column_done = 1'b1;
          phase_d           = PH_DONE;
        end else begin
          if (data_byte_i != 8'd0) begin
            col_off_d = '0;
          end
          top_d   = data_byte_i;
          phase_d = PH_LEN;
        end
      end
      PH_LEN: begin
        len_d     = data_byte_i;
        pos_d     = '0;
        written_d = '0;
        phase_d   = PH_PAD1;
      end
      PH_PAD1: begin
        phase_d = (len_c == 8'd0) ? PH_PAD2 : PH_PIX;
      end
      PH_PIX: begin
        if (row_ok) begin
          res_o.valid       = 1'b1;
          res_o.row         = r_row[7:0];
          res_o.pixel_index = data_byte_i;
          if (written_c != 9'h1FF) begin
            written_d = written_c + 9'd1;
          end
        end
        pos_d = pos_inc;
        if (pos_inc >= len_c || pos_inc == 8'd0) begin
          phase_d = PH_PAD2;
        end
      end
      PH_PAD2: begin
        col_off_d = off_sum[9] ? 9'h1FF : off_sum[8:0];
        written_d = '0;
        phase_d   = PH_TOP;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_TOP;
      top_q     <= '0;
      len_q     <= '0;
      pos_q     <= '0;
      col_off_q <= '0;
      written_q <= '0;
    end else if (step_i) begin
      phase_q   <= phase_d;
      top_q     <= top_d;
      len_q     <= len_d;
      pos_q     <= pos_d;
      col_off_q <= col_off_d;
      written_q <= written_d;
    end
  end

endmodule

`default_nettype wire

/* sv/patch_column_post_decoder.sv */
// top level of the patch column post decoder
//
// Takes the byte stream of one picture patch column, one byte per beat, and
// returns one beat per visible pixel (row and palette index) plus one beat
// with column_done set when the 0xFF terminator closes the column. Bytes
// pass an input register, combinational parse logic and a result register,
// so the block sustains one byte per cycle; it stalls only while the result
// register is full and not taken. column_start_i on a byte restarts the
// parse with that byte as the first top-delta. Configuration must be
// written only while no beat is in flight; the block does not enforce it.
`default_nettype none

module patch_column_post_decoder #(
  parameter int MAX_HEIGHT = pcpd_pkg::MaxHeightDef
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [pcpd_pkg::CfgIndexW-1:0] cfg_index_i,
  input  wire logic [pcpd_pkg::CfgDataW-1:0]  cfg_data_i,
  input  wire logic                           in_valid_i,
  output      logic                           in_ready_o,
  input  wire logic [7:0]                     data_byte_i,
  input  wire logic                           column_start_i,
  output      logic                           out_valid_o,
  input  wire logic                           out_ready_i,
  output      logic [7:0]                     row_o,
  output      logic [7:0]                     pixel_index_o,
  output      logic                           column_done_o
);
  import pcpd_pkg::*;

  cfg_t    cfg;
  result_t res;

  logic       in_valid_q, in_valid_d;
  logic [7:0] byte_q;
  logic       start_q;
  logic       out_valid_q, out_valid_d;
  logic [7:0] row_q, pix_q;
  logic       done_q;
  logic       out_free, step, in_accept;

  pcpd_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  pcpd_parser #(
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_parser (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .step_i         (step),
    .data_byte_i    (byte_q),
    .column_start_i (start_q),
    .cfg_i          (cfg),
    .res_o          (res)
  );

  assign out_free   = !out_valid_q || out_ready_i;
  assign step       = in_valid_q && out_free;
  assign in_ready_o = !in_valid_q || out_free;
  assign in_accept  = in_valid_i && in_ready_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_accept) begin
      in_valid_d = 1'b1;
    end else if (step) begin
      in_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (step) begin
      out_valid_d = res.valid;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      byte_q  <= data_byte_i;
      start_q <= column_start_i;
    end
    if (step && res.valid) begin
      row_q  <= res.row;
      pix_q  <= res.pixel_index;
      done_q <= res.column_done;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign row_o         = row_q;
  assign pixel_index_o = pix_q;
  assign column_done_o = done_q;

endmodule

`default_nettype wire
